// ----- rtl/core/brt_pkg.sv -----
package brt_pkg;

	// glyph geometry and character codes
	localparam int CHAR_W      = 8;
	localparam int LINE_H      = 16;
	localparam int FIRST_PRINT = 32;
	localparam int LAST_PRINT  = 126;
	localparam int CODE_NUL    = 0;
	localparam int CODE_NL     = 10;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// stream widths, whole bytes
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 160;

	// command carried in tuser
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// register indexes on the apb port
	localparam logic [1:0] REG_FB_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FB_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ROW_PITCH = 2'd2;
	localparam logic [1:0] REG_BG_ARGB   = 2'd3;

	typedef enum logic {
		KIND_LOAD,
		KIND_DRAW
	} kind_t;

	// one queued job: glyph byte write or character draw
	typedef struct packed {
		kind_t       kind;
		logic [6:0]  glyph;
		logic [3:0]  gbyte;
		logic [7:0]  gval;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] color;
	} job_t;

	// geometry registers seen by the back end
	typedef struct packed {
		logic [15:0] fb_width;
		logic [15:0] fb_height;
		logic [17:0] row_pitch;
	} cfg_t;

endpackage

// ----- rtl/core/brt_fifo.sv -----
module brt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  brt_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output brt_pkg::job_t head
);
	import brt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full       = (cnt_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue underflow");

endmodule

// ----- rtl/core/brt_front.sv -----
module brt_front #(
	parameter int GLYPH_COUNT = 95
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [brt_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          q_full,
	output logic                          push,
	output brt_pkg::job_t                 push_job
);
	import brt_pkg::*;

	logic        accept;
	logic [6:0]  gidx;
	logic [3:0]  gbyte;
	logic [7:0]  gval;
	logic        start;
	logic [31:0] ox;
	logic [31:0] oy;
	logic [7:0]  code;
	logic [31:0] color;

	logic [31:0] cursor_x_q;
	logic [31:0] cursor_y_q;
	logic [31:0] line_x_q;
	logic [31:0] cursor_x_n;
	logic [31:0] cursor_y_n;
	logic [31:0] line_x_n;

	assign gidx  = s_tdata[6:0];
	assign gbyte = s_tdata[10:7];
	assign gval  = s_tdata[18:11];
	assign start = s_tdata[19];
	assign ox    = s_tdata[51:20];
	assign oy    = s_tdata[83:52];
	assign code  = s_tdata[91:84];
	assign color = s_tdata[123:92];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;

	always_comb begin
		cursor_x_n     = cursor_x_q;
		cursor_y_n     = cursor_y_q;
		line_x_n       = line_x_q;
		push           = 1'b0;
		push_job       = '0;
		push_job.kind  = KIND_LOAD;
		push_job.glyph = gidx;
		push_job.gbyte = gbyte;
		push_job.gval  = gval;
		push_job.color = color;
		if (accept) begin
			if (s_tuser == CMD_LOAD) begin
				// loads beyond the store are dropped here
				push = (int'(gidx) < GLYPH_COUNT);
			end else begin
				if (start) begin
					cursor_x_n = ox;
					line_x_n   = ox;
					cursor_y_n = oy;
				end
				priority if (code == 8'(CODE_NUL)) begin
					push = 1'b0;
				end else if (code == 8'(CODE_NL)) begin
					cursor_x_n = line_x_n;
					cursor_y_n = cursor_y_n + 32'(LINE_H);
				end else begin
					push          = 1'b1;
					push_job.kind = KIND_DRAW;
					push_job.x    = cursor_x_n;
					push_job.y    = cursor_y_n;
					// unprintable codes fall back to the space glyph
					if (code < 8'(FIRST_PRINT) || code > 8'(LAST_PRINT)) begin
						push_job.glyph = '0;
					end else begin
						push_job.glyph = 7'(code - 8'(FIRST_PRINT));
					end
					cursor_x_n = cursor_x_n + 32'(CHAR_W);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			line_x_q   <= '0;
		end else begin
			cursor_x_q <= cursor_x_n;
			cursor_y_q <= cursor_y_n;
			line_x_q   <= line_x_n;
		end
	end

endmodule

// ----- rtl/core/brt_back.sv -----
module brt_back #(
	parameter int GLYPH_COUNT = 95
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brt_pkg::cfg_t                  cfg,
	input  logic                           head_valid,
	input  brt_pkg::job_t                  head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [brt_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);
	import brt_pkg::*;

	localparam int ROWS   = GLYPH_COUNT * CHAR_W;
	localparam int ADDR_W = $clog2(ROWS);

	// top and bottom glyph halves, one column per word
	logic [7:0] top_mem [ROWS];
	logic [7:0] bot_mem [ROWS];

	logic              adv;
	logic              issue_draw;
	logic              do_load;
	logic [2:0]        col_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       colx;
	logic [31:0]       prod;
	logic [15:0]       wr_rows;
	logic [31:0]       row_sum [LINE_H];

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [31:0]       colx_s1;
	logic [31:0]       top_s1;
	logic [31:0]       prod_s1;
	logic [31:0]       color_s1;
	logic              last_s1;

	logic              valid_s2;
	logic [31:0]       colx_s2;
	logic [31:0]       top_s2;
	logic [31:0]       off_s2;
	logic [15:0]       wr_s2;
	logic [31:0]       color_s2;
	logic              last_s2;
	logic [7:0]        top_rd_s2;
	logic [7:0]        bot_rd_s2;

	assign adv        = !valid_s2 || m_tready;
	assign issue_draw = head_valid && (head.kind == KIND_DRAW) && adv;
	assign do_load    = head_valid && (head.kind == KIND_LOAD) && adv;
	assign pop        = do_load || (issue_draw && (col_q == 3'(CHAR_W - 1)));

	assign rd_addr = ADDR_W'({head.glyph, col_q});
	assign wr_addr = ADDR_W'({head.glyph, head.gbyte[2:0]});
	assign colx    = head.x + 32'(col_q);
	assign prod    = head.y * {14'd0, cfg.row_pitch};

	// clipping mask, sums wrap like the cursor
	always_comb begin
		for (int r = 0; r < LINE_H; r++) begin
			row_sum[r] = top_s1 + 32'(r);
			wr_rows[r] = (colx_s1 < {16'd0, cfg.fb_width}) &&
				(row_sum[r] < {16'd0, cfg.fb_height});
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			if (!head.gbyte[3]) begin
				top_mem[wr_addr] <= head.gval;
			end else begin
				bot_mem[wr_addr] <= head.gval;
			end
		end
		if (adv) begin
			top_rd_s2 <= top_mem[addr_s1];
			bot_rd_s2 <= bot_mem[addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1  <= rd_addr;
			colx_s1  <= colx;
			top_s1   <= head.y;
			prod_s1  <= prod;
			color_s1 <= head.color;
			last_s1  <= (col_q == 3'(CHAR_W - 1));
			colx_s2  <= colx_s1;
			top_s2   <= top_s1;
			off_s2   <= prod_s1 + {colx_s1[29:0], 2'b00};
			wr_s2    <= wr_rows;
			color_s2 <= color_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue_draw) begin
				col_q <= col_q + 1'b1;
			end
			if (adv) begin
				valid_s1 <= issue_draw;
				valid_s2 <= valid_s1;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {color_s2, wr_s2, bot_rd_s2, top_rd_s2, off_s2, top_s2, colx_s2};

	a_col_on_draw: assert property (@(posedge clk) disable iff (!arst_n)
		col_q != '0 |-> head_valid && head.kind == KIND_DRAW)
		else $error("column counter running without a character at the head");

	a_columns_follow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_s1 && adv |=> valid_s1)
		else $error("gap inside a character");

	a_column_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !last_s2 && m_tready |=> valid_s2 && colx_s2 == $past(colx_s2) + 32'd1)
		else $error("column sequence broken");

endmodule

// ----- rtl/core/bitmap_text_renderer_top.sv -----
// bitmap text renderer: draws 8x16 glyphs into a 32-bit argb framebuffer, one glyph column
// per output transaction. load the glyph store first with tuser = 0 transactions (byte 0-7
// are the top-half columns, 8-15 the bottom half, bit r is row r), then send characters with
// tuser = 1. a character with start_req set restarts the cursor at its origin; code 10 is a
// newline, code 0 does nothing, other codes outside 32..126 draw as a space. each drawn
// character yields eight column transactions, tlast on the eighth, and moves the cursor right
// by 8. the back end handles a glyph load or one column per cycle while the output is not
// stalled, paced by its column counter and its single glyph-store read per cycle; each
// column passes the s1 and s2 registers before it is presented. a four-entry queue between
// the input side and the drawing side keeps the input taking transactions while output
// stalls. the glyph store has no reset and no clearing pass: unwritten entries read as
// anything.
// geometry registers sit on the apb port at byte addresses 0, 4, 8 and 12 and must only be
// written while the block is idle.
module bitmap_text_renderer_top #(
	parameter int GLYPH_COUNT = 95
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// apb configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// glyph_index[6:0], glyph_byte[10:7], glyph_value[18:11], start_req[19],
	// origin_x[51:20], origin_y[83:52], code[91:84], text_color[123:92], zero pad
	input  logic [brt_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd[0]
	input  logic                           s_tuser,
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// column_x[31:0], top_row[63:32], byte_offset[95:64], fg_rows[111:96],
	// write_rows[127:112], fg_color[159:128]
	output logic [brt_pkg::OUT_DATA_W-1:0] m_tdata,
	// last column of the character
	output logic                           m_tlast
);
	import brt_pkg::*;

	cfg_t        cfg_q;
	logic [31:0] bg_argb_q;
	logic        cfg_wr;
	logic [1:0]  reg_idx;

	logic        push;
	job_t        push_job;
	logic        q_full;
	logic        head_valid;
	job_t        head;
	logic        pop;

	// register file, write lands on the access phase
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width  <= 16'd640;
			cfg_q.fb_height <= 16'd480;
			cfg_q.row_pitch <= 18'd2560;
			bg_argb_q       <= 32'hFF00_0000;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FB_WIDTH:  cfg_q.fb_width  <= pwdata[15:0];
				REG_FB_HEIGHT: cfg_q.fb_height <= pwdata[15:0];
				REG_ROW_PITCH: cfg_q.row_pitch <= pwdata[17:0];
				REG_BG_ARGB:   bg_argb_q       <= pwdata;
				default:       bg_argb_q       <= bg_argb_q;
			endcase
		end
	end

	// background colour is only held in a register here and read back, not passed on
	always_comb begin
		unique case (reg_idx)
			REG_FB_WIDTH:  prdata = {16'd0, cfg_q.fb_width};
			REG_FB_HEIGHT: prdata = {16'd0, cfg_q.fb_height};
			REG_ROW_PITCH: prdata = {14'd0, cfg_q.row_pitch};
			REG_BG_ARGB:   prdata = bg_argb_q;
			default:       prdata = '0;
		endcase
	end

	// front end: accepts transactions, tracks the cursor, sorts out codes
	brt_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// job queue, keeps loads and draws in order so glyph writes never overtake reads
	brt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back end: glyph store, column sequencing, address and clipping
	brt_back #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
